// File: src/cos_pkg.sv
// Shared constants and elaboration-time helpers for the circular orbit step core.
// Holds field widths, register codes, angle constants and CORDIC table functions.
// No dependencies.
`timescale 1ns / 1ps

package cos_pkg;

  localparam int WORD_W = 32;
  localparam int DIR_W  = 2;
  localparam int CFG_IDX_W = 1;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_SCALE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP     = 1'b1;

  localparam logic [WORD_W-1:0] GRAVITY_SCALE_RST = 32'd65536;
  localparam logic [WORD_W-1:0] TIME_STEP_RST     = 32'd71582788;

  localparam int TRIG_ITER_DEF = 24;

  // pi in Q.60 and the derived angles
  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
  localparam logic [35:0] HALF_PI_Q32 = 36'((PI_Q60 + (64'd1 << 28)) >> 29);
  localparam logic [35:0] PI_Q32      = 36'((PI_Q60 + (64'd1 << 27)) >> 28);
  localparam logic [35:0] TWO_PI_Q32  = 36'((PI_Q60 + (64'd1 << 26)) >> 27);

  // shift-subtract quotient, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = {rem[63:0], a[k]};
      if (rem >= {1'b0, b}) begin
        rem  = rem - {1'b0, b};
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bt;
    logic [63:0] rem;
    res = '0;
    bt  = 64'd1 << 62;
    rem = v;
    for (int k = 0; k < 32; k++) begin
      if (rem >= res + bt) begin
        rem = rem - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // arctangent of 2^-i in Q.32, rounded from a Q.62 series sum
  function automatic logic [31:0] atan_q32(input int i);
    logic [63:0] v;
    logic [63:0] p;
    logic [63:0] t;
    v = '0;
    if (i == 0) begin
      v = PI_Q60;
    end else begin
      p = 64'd1 << (62 - i);
      for (int k = 0; k < 32; k++) begin
        if (p != 0) begin
          t = udiv64(p, 64'(2 * k + 1));
          if ((k % 2) == 0) v = v + t;
          else v = v - t;
          p = p >> (2 * i);
        end
      end
    end
    return 32'((v + (64'd1 << 29)) >> 30);
  endfunction

  // inverse CORDIC gain in Q.31 after n steps
  function automatic logic [31:0] gain_q31(input int n);
    logic [63:0] k2;
    logic [63:0] root;
    k2 = 64'd1 << 62;
    for (int i = 0; i < n; i++) begin
      k2 = k2 - udiv64(k2, (64'd1 << (2 * i)) + 64'd1);
    end
    root = isqrt64(k2);
    return root[31:0];
  endfunction

endpackage

// File: src/cos_ifs.sv
// Valid/ready channel interfaces of the circular orbit step core.
// Depends on cos_pkg for field widths.
`timescale 1ns / 1ps

interface cos_in_if;
  import cos_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] radius;
  logic        [WORD_W-1:0] center_mass;
  logic signed [DIR_W-1:0]  direction;
  logic        [WORD_W-1:0] phase_in;
  logic signed [WORD_W-1:0] center_x;
  logic signed [WORD_W-1:0] center_y;
  modport source (output valid, radius, center_mass, direction, phase_in, center_x,
                  center_y, input ready);
  modport sink (input valid, radius, center_mass, direction, phase_in, center_x,
                center_y, output ready);
endinterface

interface cos_out_if;
  import cos_pkg::*;
  logic                     valid;
  logic                     ready;
  logic        [WORD_W-1:0] phase_out;
  logic signed [WORD_W-1:0] pos_x;
  logic signed [WORD_W-1:0] pos_y;
  logic signed [WORD_W-1:0] vel_x;
  logic signed [WORD_W-1:0] vel_y;
  logic signed [WORD_W-1:0] angular_rate;
  modport source (output valid, phase_out, pos_x, pos_y, vel_x, vel_y, angular_rate,
                  input ready);
  modport sink (input valid, phase_out, pos_x, pos_y, vel_x, vel_y, angular_rate,
                output ready);
endinterface

interface cos_cfg_if;
  import cos_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WORD_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: src/circular_orbit_step_core.sv
// Circular orbit step core: pipelined angular speed, angle advance and CORDIC trig.
// Depends on cos_pkg and the channel interfaces in cos_ifs.sv.
`timescale 1ns / 1ps

//  channel | dir | handshake    | carries
//  --------+-----+--------------+-----------------------------------------------
//  in_if   | in  | valid/ready  | radius, center_mass, direction, phase, center
//  out_if  | out | valid/ready  | phase_out, pos_x/y, vel_x/y, angular_rate
//  cfg_if  | in  | valid/ready  | register index, data (always ready)
//
// One item enters per cycle while the output is not stalled. The pipe depth is set
// mostly by the 62-step restoring divider, the 31-step square root and the CORDIC,
// each one step per stage.
// Reset clears the valid bits and loads the register defaults; payload is not reset.
// A stall at the output freezes every stage at once; in_if.ready follows it.
// Items with a non-positive radius enter as bubbles and give no result.

module circular_orbit_step_core #(
  parameter int TRIG_ITERATIONS = cos_pkg::TRIG_ITER_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  cos_in_if.sink        in_if,
  cos_out_if.source     out_if,
  cos_cfg_if.sink       cfg_if
);
  import cos_pkg::*;

  localparam int DIV_STEPS  = 62;
  localparam int SQRT_STEPS = 31;
  localparam int SAT_W      = 44;

  // stage map
  localparam int ST_IN   = 0;
  localparam int ST_MUL1 = 1;
  localparam int ST_MUL2 = 2;
  localparam int ST_CUBE = 3;
  localparam int ST_SAT  = 4;
  localparam int ST_DIV0 = 5;
  localparam int ST_SQ0  = ST_DIV0 + DIV_STEPS;
  localparam int ST_RATE = ST_SQ0 + SQRT_STEPS;
  localparam int ST_PROD = ST_RATE + 1;
  localparam int ST_RED1 = ST_PROD + 1;
  localparam int ST_RED2 = ST_RED1 + 1;
  localparam int ST_RED3 = ST_RED2 + 1;
  localparam int ST_WRAP = ST_RED3 + 1;
  localparam int ST_PRE  = ST_WRAP + 1;
  localparam int ST_CR0  = ST_PRE + 1;
  localparam int ST_P1   = ST_CR0 + TRIG_ITERATIONS;
  localparam int ST_P2   = ST_P1 + 1;
  localparam int ST_OUT  = ST_P2 + 1;
  localparam int NSTAGE  = ST_OUT + 1;

  localparam logic signed [33:0] GAIN = 34'(gain_q31(TRIG_ITERATIONS));

  typedef struct packed {
    logic        [30:0] r;
    logic        [1:0]  dir;
    logic        [31:0] phase;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic        [63:0] gm;
    logic        [61:0] rr;
    logic        [61:0] plo;
    logic        [61:0] phi;
    logic        [92:0] d;
    logic        [92:0] rem;
    logic        [61:0] q;
    logic               sat;
    logic               zero;
    logic        [61:0] sv;
    logic        [61:0] sres;
    logic        [30:0] w;
    logic               neg;
    logic signed [31:0] rate;
    logic        [35:0] delta;
    logic        [37:0] vrm;
    logic        [31:0] pm;
    logic        [31:0] theta;
    logic signed [35:0] z;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic               tneg;
    logic        [64:0] rc;
    logic        [64:0] rs;
    logic        [65:0] vlc;
    logic        [65:0] vls;
    logic        [39:0] vhc;
    logic        [39:0] vhs;
    logic               cneg;
    logic               sneg;
    logic signed [34:0] prc;
    logic signed [34:0] prs;
    logic signed [41:0] pvx;
    logic signed [41:0] pvy;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
  } item_t;

  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [31:0] res;
    if (v > SAT_W'(signed'(32'sh7FFFFFFF))) res = 32'sh7FFFFFFF;
    else if (v < SAT_W'(signed'(32'sh80000000))) res = 32'sh80000000;
    else res = v[31:0];
    return res;
  endfunction

  // one conditional subtract of 2*pi scaled by 2^k
  function automatic logic [35:0] red_step(input logic [35:0] v, input int k);
    logic [35:0] m;
    m = 36'(TWO_PI_Q29) << k;
    return (v >= m) ? v - m : v;
  endfunction

  logic [WORD_W-1:0] gs_q, ts_q;
  logic [NSTAGE-1:0] vld_q, vld_d;
  item_t             pipe_q [NSTAGE];
  item_t             pipe_d [NSTAGE];
  logic              en;

  // ---------------------------------------------------------------- config
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gs_q <= GRAVITY_SCALE_RST;
      ts_q <= TIME_STEP_RST;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        CFG_GRAVITY_SCALE: gs_q <= cfg_if.data;
        CFG_TIME_STEP:     ts_q <= cfg_if.data;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow
  // Advance the whole pipe unless a finished item waits at the output.
  assign en          = !vld_q[NSTAGE-1] || out_if.ready;
  assign in_if.ready = en;
  // Drop a non-positive radius here: it rides along as a bubble.
  assign vld_d = {vld_q[NSTAGE-2:0],
                  in_if.valid && !in_if.radius[31] && (in_if.radius != '0)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= vld_d;
  end

  always_ff @(posedge clk_i) begin
    if (en) pipe_q <= pipe_d;
  end

  // ---------------------------------------------------------------- stages
  for (genvar k = 0; k < NSTAGE; k++) begin : g_st
    if (k == ST_IN) begin : g_in
      always_comb begin
        pipe_d[k]       = '0;
        pipe_d[k].r     = in_if.radius[30:0];
        pipe_d[k].dir   = in_if.direction;
        pipe_d[k].phase = in_if.phase_in;
        pipe_d[k].cx    = in_if.center_x;
        pipe_d[k].cy    = in_if.center_y;
        pipe_d[k].gm    = {32'd0, in_if.center_mass};
      end
    end else if (k == ST_MUL1) begin : g_mul1
      // gm = G * M, rr = r^2
      always_comb begin
        pipe_d[k]    = pipe_q[k-1];
        pipe_d[k].gm = 64'(pipe_q[k-1].gm[31:0]) * 64'(gs_q);
        pipe_d[k].rr = 62'(pipe_q[k-1].r) * 62'(pipe_q[k-1].r);
      end
    end else if (k == ST_MUL2) begin : g_mul2
      // r^3 in two 31-bit partial products
      always_comb begin
        pipe_d[k]     = pipe_q[k-1];
        pipe_d[k].plo = 62'(pipe_q[k-1].rr[30:0]) * 62'(pipe_q[k-1].r);
        pipe_d[k].phi = 62'(pipe_q[k-1].rr[61:31]) * 62'(pipe_q[k-1].r);
      end
    end else if (k == ST_CUBE) begin : g_cube
      always_comb begin
        pipe_d[k]   = pipe_q[k-1];
        pipe_d[k].d = 93'(pipe_q[k-1].plo) + {pipe_q[k-1].phi, 31'd0};
      end
    end else if (k == ST_SAT) begin : g_sat
      // The quotient's top 82 bits are zero unless G*M*2^18 reaches r^3;
      // start the divider with that partial remainder.
      always_comb begin
        pipe_d[k]      = pipe_q[k-1];
        pipe_d[k].sat  = 93'({pipe_q[k-1].gm, 18'd0}) >= pipe_q[k-1].d;
        pipe_d[k].zero = (pipe_q[k-1].dir == 2'b00) || (pipe_q[k-1].gm == '0);
        pipe_d[k].rem  = 93'({pipe_q[k-1].gm, 18'd0});
        pipe_d[k].q    = '0;
      end
    end else if (k >= ST_DIV0 && k < ST_SQ0) begin : g_div
      always_comb begin
        logic [93:0] rem2;
        pipe_d[k] = pipe_q[k-1];
        rem2      = {pipe_q[k-1].rem, 1'b0};
        if (rem2 >= {1'b0, pipe_q[k-1].d}) begin
          pipe_d[k].rem = 93'(rem2 - {1'b0, pipe_q[k-1].d});
          pipe_d[k].q   = {pipe_q[k-1].q[60:0], 1'b1};
        end else begin
          pipe_d[k].rem = rem2[92:0];
          pipe_d[k].q   = {pipe_q[k-1].q[60:0], 1'b0};
        end
        if (k == ST_DIV0 + DIV_STEPS - 1) begin
          pipe_d[k].sv   = pipe_d[k].q;
          pipe_d[k].sres = '0;
        end
      end
    end else if (k >= ST_SQ0 && k < ST_RATE) begin : g_sqrt
      // the quotient stays below 2^62, so the root starts at bit weight 2^60
      localparam int SI = k - ST_SQ0 + 1;
      localparam logic [61:0] SBIT = 62'(64'd1 << (62 - 2 * SI));
      always_comb begin
        logic [62:0] trial;
        pipe_d[k] = pipe_q[k-1];
        trial     = {1'b0, pipe_q[k-1].sres} + {1'b0, SBIT};
        if ({1'b0, pipe_q[k-1].sv} >= trial) begin
          pipe_d[k].sv   = 62'({1'b0, pipe_q[k-1].sv} - trial);
          pipe_d[k].sres = (pipe_q[k-1].sres >> 1) + SBIT;
        end else begin
          pipe_d[k].sres = pipe_q[k-1].sres >> 1;
        end
      end
    end else if (k == ST_RATE) begin : g_rate
      always_comb begin
        logic [30:0] w;
        pipe_d[k] = pipe_q[k-1];
        if (pipe_q[k-1].zero) w = '0;
        else if (pipe_q[k-1].sat) w = 31'h7FFFFFFF;
        else w = pipe_q[k-1].sres[30:0];
        pipe_d[k].w    = w;
        pipe_d[k].neg  = pipe_q[k-1].dir[1];
        pipe_d[k].rate = pipe_q[k-1].dir[1] ? (32'sd0 - $signed({1'b0, w}))
                                            : $signed({1'b0, w});
      end
    end else if (k == ST_PROD) begin : g_prod
      // angle advance w*dt in Q3.29, and |w|*r in Q16.16
      always_comb begin
        logic [62:0] pt;
        logic [61:0] pr;
        pipe_d[k]       = pipe_q[k-1];
        pt              = 63'(pipe_q[k-1].w) * 63'(ts_q);
        pr              = 62'(pipe_q[k-1].w) * 62'(pipe_q[k-1].r);
        pipe_d[k].delta = pt[62:27];
        pipe_d[k].vrm   = pr[61:24];
      end
    end else if (k == ST_RED1) begin : g_red1
      always_comb begin
        pipe_d[k]       = pipe_q[k-1];
        pipe_d[k].pm    = (pipe_q[k-1].phase >= TWO_PI_Q29) ?
                          pipe_q[k-1].phase - TWO_PI_Q29 : pipe_q[k-1].phase;
        pipe_d[k].delta = red_step(red_step(pipe_q[k-1].delta, 4), 3);
      end
    end else if (k == ST_RED2) begin : g_red2
      always_comb begin
        pipe_d[k]       = pipe_q[k-1];
        pipe_d[k].delta = red_step(red_step(pipe_q[k-1].delta, 2), 1);
      end
    end else if (k == ST_RED3) begin : g_red3
      always_comb begin
        pipe_d[k]       = pipe_q[k-1];
        pipe_d[k].delta = red_step(pipe_q[k-1].delta, 0);
      end
    end else if (k == ST_WRAP) begin : g_wrap
      always_comb begin
        logic [32:0] sum;
        logic [31:0] pm, dm;
        pipe_d[k] = pipe_q[k-1];
        pm        = pipe_q[k-1].pm;
        dm        = pipe_q[k-1].delta[31:0];
        sum       = {1'b0, pm} + {1'b0, dm};
        if (!pipe_q[k-1].neg) begin
          pipe_d[k].theta = (sum >= {1'b0, TWO_PI_Q29}) ? 32'(sum - {1'b0, TWO_PI_Q29})
                                                        : sum[31:0];
        end else begin
          pipe_d[k].theta = (pm >= dm) ? pm - dm : pm + (TWO_PI_Q29 - dm);
        end
      end
    end else if (k == ST_PRE) begin : g_pre
      // fold the angle into [-pi/2, pi/2], flipping the vector for the middle half
      always_comb begin
        logic [35:0] a;
        pipe_d[k]      = pipe_q[k-1];
        a              = {1'b0, pipe_q[k-1].theta, 3'd0};
        pipe_d[k].x    = GAIN;
        pipe_d[k].y    = '0;
        pipe_d[k].tneg = 1'b0;
        if (a > HALF_PI_Q32 && a < PI_Q32 + HALF_PI_Q32) begin
          pipe_d[k].z    = $signed(a - PI_Q32);
          pipe_d[k].tneg = 1'b1;
        end else if (a >= PI_Q32 + HALF_PI_Q32) begin
          pipe_d[k].z = $signed(a - TWO_PI_Q32);
        end else begin
          pipe_d[k].z = $signed(a);
        end
      end
    end else if (k >= ST_CR0 && k < ST_P1) begin : g_cordic
      localparam int CI = k - ST_CR0;
      localparam logic signed [35:0] ATAN = 36'(atan_q32(CI));
      always_comb begin
        logic signed [33:0] dx, dy;
        pipe_d[k] = pipe_q[k-1];
        dx        = pipe_q[k-1].y >>> CI;
        dy        = pipe_q[k-1].x >>> CI;
        if (pipe_q[k-1].z >= 0) begin
          pipe_d[k].x = pipe_q[k-1].x - dx;
          pipe_d[k].y = pipe_q[k-1].y + dy;
          pipe_d[k].z = pipe_q[k-1].z - ATAN;
        end else begin
          pipe_d[k].x = pipe_q[k-1].x + dx;
          pipe_d[k].y = pipe_q[k-1].y - dy;
          pipe_d[k].z = pipe_q[k-1].z + ATAN;
        end
      end
    end else if (k == ST_P1) begin : g_p1
      // magnitude products; signs travel beside them
      always_comb begin
        logic [33:0] ax, ay;
        pipe_d[k]      = pipe_q[k-1];
        ax             = pipe_q[k-1].x[33] ? 34'(-pipe_q[k-1].x) : 34'(pipe_q[k-1].x);
        ay             = pipe_q[k-1].y[33] ? 34'(-pipe_q[k-1].y) : 34'(pipe_q[k-1].y);
        pipe_d[k].cneg = pipe_q[k-1].x[33] ^ pipe_q[k-1].tneg;
        pipe_d[k].sneg = pipe_q[k-1].y[33] ^ pipe_q[k-1].tneg;
        pipe_d[k].rc   = 65'(pipe_q[k-1].r) * 65'(ax);
        pipe_d[k].rs   = 65'(pipe_q[k-1].r) * 65'(ay);
        pipe_d[k].vlc  = 66'(pipe_q[k-1].vrm[31:0]) * 66'(ax);
        pipe_d[k].vls  = 66'(pipe_q[k-1].vrm[31:0]) * 66'(ay);
        pipe_d[k].vhc  = 40'(pipe_q[k-1].vrm[37:32]) * 40'(ax);
        pipe_d[k].vhs  = 40'(pipe_q[k-1].vrm[37:32]) * 40'(ay);
      end
    end else if (k == ST_P2) begin : g_p2
      // drop the Q.31 fraction toward zero, then apply the sign
      always_comb begin
        logic [71:0] vc, vs;
        logic [33:0] mc, ms;
        logic [40:0] mvc, mvs;
        pipe_d[k]     = pipe_q[k-1];
        vc            = {pipe_q[k-1].vhc, 32'd0} + 72'(pipe_q[k-1].vlc);
        vs            = {pipe_q[k-1].vhs, 32'd0} + 72'(pipe_q[k-1].vls);
        mc            = pipe_q[k-1].rc[64:31];
        ms            = pipe_q[k-1].rs[64:31];
        mvc           = vc[71:31];
        mvs           = vs[71:31];
        pipe_d[k].prc = pipe_q[k-1].cneg ? -$signed({1'b0, mc}) : $signed({1'b0, mc});
        pipe_d[k].prs = pipe_q[k-1].sneg ? -$signed({1'b0, ms}) : $signed({1'b0, ms});
        // vel_x = -(w*r)*s, vel_y = (w*r)*c
        pipe_d[k].pvx = (pipe_q[k-1].neg ^ pipe_q[k-1].sneg) ? $signed({1'b0, mvs})
                                                             : -$signed({1'b0, mvs});
        pipe_d[k].pvy = (pipe_q[k-1].neg ^ pipe_q[k-1].cneg) ? -$signed({1'b0, mvc})
                                                             : $signed({1'b0, mvc});
      end
    end else begin : g_out
      always_comb begin
        pipe_d[k]    = pipe_q[k-1];
        pipe_d[k].px = sat32(SAT_W'(pipe_q[k-1].cx) + SAT_W'(pipe_q[k-1].prc));
        pipe_d[k].py = sat32(SAT_W'(pipe_q[k-1].cy) + SAT_W'(pipe_q[k-1].prs));
        pipe_d[k].vx = sat32(SAT_W'(pipe_q[k-1].pvx));
        pipe_d[k].vy = sat32(SAT_W'(pipe_q[k-1].pvy));
      end
    end
  end

  // ---------------------------------------------------------------- output
  assign out_if.valid        = vld_q[NSTAGE-1];
  assign out_if.phase_out    = pipe_q[NSTAGE-1].theta;
  assign out_if.pos_x        = pipe_q[NSTAGE-1].px;
  assign out_if.pos_y        = pipe_q[NSTAGE-1].py;
  assign out_if.vel_x        = pipe_q[NSTAGE-1].vx;
  assign out_if.vel_y        = pipe_q[NSTAGE-1].vy;
  assign out_if.angular_rate = pipe_q[NSTAGE-1].rate;

  // ---------------------------------------------------------------- checks
  // a stall holds every valid bit in place
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> vld_q == $past(vld_q))
    else $error("valid bits moved during a stall");

  // the advanced angle is always wrapped into [0, 2*pi)
  a_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NSTAGE-1] |-> pipe_q[NSTAGE-1].theta < TWO_PI_Q29)
    else $error("phase_out not wrapped");

  // a body at rest has no velocity
  a_rest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NSTAGE-1] && pipe_q[NSTAGE-1].rate == '0) |->
      (pipe_q[NSTAGE-1].vx == '0 && pipe_q[NSTAGE-1].vy == '0))
    else $error("velocity without angular speed");

endmodule
